// ===== hw/rtl/mtfe_pkg.sv =====
// Package for the meter trailer field extractor.
// Holds the item type, record kinds, section layout constants and the battery table.
// No dependencies; every module of the block imports it.
package mtfe_pkg;

	localparam int MAX_TRAILER_LEN = 255;
	localparam int MONTHS_SHOWN    = 4;
	localparam int NUM_SECTIONS    = 5;
	localparam int HIST_SIZE       = 3 * MONTHS_SHOWN;
	localparam int HIST_NEED       = 36;
	localparam int OFF_W           = 6;
	localparam logic [23:0] HISTORY_LIMIT = 24'd10000000;

	typedef enum logic [2:0] {
		KIND_BATTERY  = 3'd0,
		KIND_FRAUD    = 3'd1,
		KIND_LEAK     = 3'd2,
		KIND_BACKFLOW = 3'd3,
		KIND_HISTORY  = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic [7:0] trailer_length;
	} item_t;

	typedef struct packed {
		logic             hit;
		kind_t            kind;
		logic [OFF_W-1:0] off;
	} loc_t;

	// Sections in trailer order: bitmap bit, bytes decoded, bytes required.
	localparam logic [7:0] SEC_BIT  [NUM_SECTIONS] = '{8'h01, 8'h02, 8'h80, 8'h04, 8'h10};
	localparam int         SEC_SIZE [NUM_SECTIONS] = '{1, 3, 3, 4, HIST_SIZE};
	localparam int         SEC_NEED [NUM_SECTIONS] = '{1, 3, 3, 4, HIST_NEED};
	localparam kind_t      SEC_KIND [NUM_SECTIONS] =
		'{KIND_BATTERY, KIND_FRAUD, KIND_LEAK, KIND_BACKFLOW, KIND_HISTORY};

	localparam logic [11:0] BATT_MV [16] = '{
		12'd3700, 12'd1900, 12'd2100, 12'd2200, 12'd2300, 12'd2400, 12'd2500, 12'd2650,
		12'd2800, 12'd2900, 12'd3050, 12'd3200, 12'd3350, 12'd3500, 12'd3700, 12'd3700
	};

endpackage

// ===== hw/rtl/mtfe_in_if.sv =====
// Byte channel into the meter trailer field extractor.
// Depends on nothing; carries valid, ready and one trailer byte with its framing.
interface mtfe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic [7:0] trailer_length;

	modport source (output valid, data_byte, first_byte, trailer_length, input ready);
	modport sink (input valid, data_byte, first_byte, trailer_length, output ready);
endinterface

// ===== hw/rtl/mtfe_out_if.sv =====
// Record channel out of the meter trailer field extractor.
// Depends on nothing; carries valid, ready and one decoded record.
interface mtfe_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  record_kind;
	logic [2:0]  month_number;
	logic [31:0] record_value;

	modport source (output valid, record_kind, month_number, record_value, input ready);
	modport sink (input valid, record_kind, month_number, record_value, output ready);
endinterface

// ===== hw/rtl/meter_trailer_field_extractor.sv =====
// Meter trailer field extractor, top level: input register and decode stage.
// Depends on mtfe_pkg, mtfe_in_if, mtfe_out_if and mtfe_core.
//
// Usage: trailer bytes enter on din, one byte per transfer. The byte with
// first_byte set is the section bitmap and carries the trailer length; the
// following bytes are the section contents. Decoded records leave on dout,
// one per completed battery, date or backflow section and one per history
// month shown.
// Path: a byte passes through the input register and the decode stage, and
// its record then sits in the output register, which drives dout. Throughput:
// one byte per cycle while dout is ready; the decode stage does all work for
// a byte combinationally between the two registers.
// Stalls: a record held in the output register blocks only a byte that
// itself produces a record; bytes that produce nothing keep flowing. Once
// the input register also holds a record-producing byte, din.ready drops
// until dout takes the pending record.
// Reset: arst_n clears the input and output valid flags and the trailer
// state, so bytes seen before any bitmap byte produce no record.
module meter_trailer_field_extractor
	import mtfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	mtfe_in_if.sink    din,
	mtfe_out_if.source dout
);

	logic  valid_s1;
	item_t item_s1;
	logic  adv;
	logic  accept;

	assign din.ready = !valid_s1 || adv;
	assign accept    = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{data_byte: din.data_byte, first_byte: din.first_byte,
				trailer_length: din.trailer_length};
		end
	end

	mtfe_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.adv      (adv),
		.dout     (dout)
	);

endmodule

// ===== hw/rtl/mtfe_locate.sv =====
// Section locator: maps a trailer position to the section that holds it.
// Depends on mtfe_pkg for the section layout and the loc_t result type.
module mtfe_locate
	import mtfe_pkg::*;
(
	input  logic [7:0] bitmap,
	input  logic [7:0] length,
	input  logic [7:0] pos,
	output loc_t       loc
);

	logic [9:0] cur;
	logic [9:0] last;

	// Sections are packed back to back; an absent one takes no bytes.
	always_comb begin
		cur = 10'd1;
		last = '0;
		loc = '{hit: 1'b0, kind: KIND_BATTERY, off: '0};
		for (int s = 0; s < NUM_SECTIONS; s++) begin
			last = cur + 10'(SEC_NEED[s]) - 10'd1;
			if ((bitmap & SEC_BIT[s]) != 8'd0 && last < {2'b00, length}) begin
				if (!loc.hit && {2'b00, pos} >= cur && {2'b00, pos} < cur + 10'(SEC_SIZE[s])) begin
					loc.hit = 1'b1;
					loc.kind = SEC_KIND[s];
					loc.off = OFF_W'({2'b00, pos} - cur);
				end
				cur = cur + 10'(SEC_SIZE[s]);
			end
		end
	end

endmodule

// ===== hw/rtl/mtfe_core.sv =====
// Decode stage: trailer state, field assembly and the record output register.
// Depends on mtfe_pkg, mtfe_locate and the mtfe_out_if interface.
module mtfe_core
	import mtfe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  item_t            item_s1,
	output logic             adv,
	mtfe_out_if.source       dout
);

	logic [7:0]  pos_q;
	logic [7:0]  bitmap_q;
	logic [7:0]  len_q;
	logic [31:0] asm_q;

	logic [7:0]  pos_n;
	logic [7:0]  bitmap_n;
	logic [7:0]  len_n;
	logic [31:0] asm_n;

	logic        res_v;
	kind_t       res_kind;
	logic [2:0]  res_month;
	logic [31:0] res_value;

	logic        out_valid_q;
	logic [2:0]  out_kind_q;
	logic [2:0]  out_month_q;
	logic [31:0] out_value_q;

	logic        out_free;
	loc_t        loc;
	logic [11:0] q_prod;
	logic [OFF_W-1:0] month_idx;
	logic [1:0]  om;
	logic [23:0] hist_val;

	mtfe_locate u_locate (
		.bitmap (bitmap_q),
		.length (len_q),
		.pos    (pos_q),
		.loc    (loc)
	);

	// Offset within history split into month and byte by a multiply by 43/128,
	// which equals a divide by three for offsets below 64.
	assign q_prod    = 12'({6'd0, loc.off} * 12'd43);
	assign month_idx = OFF_W'(q_prod >> 7);
	assign om        = 2'(loc.off - OFF_W'(month_idx * 3));

	assign out_free = !out_valid_q || dout.ready;
	assign adv      = valid_s1 && (!res_v || out_free);

	always_comb begin
		pos_n     = pos_q;
		bitmap_n  = bitmap_q;
		len_n     = len_q;
		asm_n     = asm_q;
		res_v     = 1'b0;
		res_kind  = KIND_BATTERY;
		res_month = '0;
		res_value = '0;
		hist_val  = '0;
		if (item_s1.first_byte) begin
			bitmap_n = item_s1.data_byte;
			len_n    = (32'(item_s1.trailer_length) > 32'(MAX_TRAILER_LEN)) ?
				8'(MAX_TRAILER_LEN) : item_s1.trailer_length;
			pos_n    = 8'd1;
			asm_n    = '0;
		end else begin
			if (pos_q != 8'hFF) begin
				pos_n = pos_q + 8'd1;
			end
			if (loc.hit) begin
				res_kind = loc.kind;
				case (loc.kind)
					KIND_BATTERY: begin
						res_v     = 1'b1;
						res_value = {20'd0, BATT_MV[item_s1.data_byte[3:0]]};
					end
					KIND_FRAUD, KIND_LEAK: begin
						// Dates arrive most significant byte first.
						asm_n     = (loc.off == '0) ? {24'd0, item_s1.data_byte} :
							{asm_q[23:0], item_s1.data_byte};
						res_v     = (loc.off == OFF_W'(2));
						res_value = {8'd0, asm_n[23:0]};
					end
					KIND_BACKFLOW: begin
						asm_n = (loc.off == '0) ? {24'd0, item_s1.data_byte} :
							asm_q | (32'(item_s1.data_byte) << {loc.off[1:0], 3'b000});
						res_v     = (loc.off == OFF_W'(3));
						res_value = asm_n;
					end
					KIND_HISTORY: begin
						asm_n = (om == 2'd0) ? {24'd0, item_s1.data_byte} :
							asm_q | (32'(item_s1.data_byte) << {om, 3'b000});
						hist_val  = (asm_n[23:0] >= HISTORY_LIMIT) ? 24'd0 : asm_n[23:0];
						res_v     = (om == 2'd2);
						res_month = 3'(month_idx + OFF_W'(1));
						res_value = {8'd0, hist_val};
					end
					default: begin
						res_v = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			bitmap_q    <= '0;
			len_q       <= '0;
			asm_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				pos_q    <= pos_n;
				bitmap_q <= bitmap_n;
				len_q    <= len_n;
				asm_q    <= asm_n;
			end
			if (out_free) begin
				out_valid_q <= adv && res_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_v) begin
			out_kind_q  <= res_kind;
			out_month_q <= res_month;
			out_value_q <= res_value;
		end
	end

	assign dout.valid        = out_valid_q;
	assign dout.record_kind  = out_kind_q;
	assign dout.month_number = out_month_q;
	assign dout.record_value = out_value_q;

endmodule
